### hw/rtl/pwfd_pkg.sv
// ----------------------------------------------------------------------------
// pwfd_pkg
// Types and constants shared by the wire-format field decoder.
// ----------------------------------------------------------------------------
package pwfd_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VALUE,
    PH_LENGTH,
    PH_SKIP,
    PH_FIX32,
    PH_DRAIN
  } phase_e;

  localparam logic [2:0] WK_VARINT  = 3'd0;
  localparam logic [2:0] WK_FIXED64 = 3'd1;
  localparam logic [2:0] WK_LEN     = 3'd2;
  localparam logic [2:0] WK_FIXED32 = 3'd5;

  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  localparam logic [15:0] FIXED64_BYTES  = 16'd8;
  localparam logic [15:0] FIXED32_BYTES  = 16'd4;

  typedef struct packed {
    phase_e       phase;
    logic [63:0]  acc;
    logic [3:0]   vcnt;
    logic [31:0]  fnum;
    logic [2:0]   kind;
    logic [15:0]  pos;
    logic [15:0]  rem;
    logic [15:0]  span;
    logic         err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_TAG,
    acc:   64'd0,
    vcnt:  4'd0,
    fnum:  32'd0,
    kind:  3'd0,
    pos:   16'd0,
    rem:   16'd0,
    span:  16'd0,
    err:   1'b0
  };

  typedef struct packed {
    logic         field_valid;
    logic [31:0]  field_number;
    logic [2:0]   wire_kind;
    logic [63:0]  field_value;
    logic [15:0]  payload_offset;
    logic [15:0]  payload_length;
    logic         end_of_message;
    logic         parse_ok;
  } result_t;

endpackage

### hw/rtl/protobuf_wire_field_decoder.sv
// A result is registered in the output buffer when the byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall_o is low, whether or not it gives a result.
// The decode of each byte is a single pass from the parser state register to the
// result register; a two-word output buffer (register plus skid) absorbs one stall.
// Reset (asynchronous, active low) returns the parser to the tag phase and empties
// the output buffer; the parser also returns to that state after every last byte.
// ----------------------------------------------------------------------------
// protobuf_wire_field_decoder
// Streaming decoder of top-level wire-format fields, one byte per word.
// ----------------------------------------------------------------------------
module protobuf_wire_field_decoder #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        field_valid_o,
  output logic [31:0] field_number_o,
  output logic [2:0]  wire_kind_o,
  output logic [63:0] field_value_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o,
  output logic        end_of_message_o,
  output logic        parse_ok_o
);

  pwfd_pkg::state_t  st_q, st_d;
  pwfd_pkg::result_t res, out_res;
  logic              res_valid;
  logic              full;
  logic              in_acc;

  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !full;

  pwfd_step #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_step (
    .st_i        (st_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .st_d_o      (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pwfd_pkg::STATE_RESET;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  pwfd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc && res_valid),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_res)
  );

  assign field_valid_o    = out_res.field_valid;
  assign field_number_o   = out_res.field_number;
  assign wire_kind_o      = out_res.wire_kind;
  assign field_value_o    = out_res.field_value;
  assign payload_offset_o = out_res.payload_offset;
  assign payload_length_o = out_res.payload_length;
  assign end_of_message_o = out_res.end_of_message;
  assign parse_ok_o       = out_res.parse_ok;

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> (st_q.phase == pwfd_pkg::PH_TAG && st_q.pos == 16'd0 &&
                                 !st_q.err))
    else $error("parser state not cleared after last byte");

  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.vcnt <= pwfd_pkg::VARINT_LAST_IDX)
    else $error("varint byte count out of range");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |-> res_valid)
    else $error("last byte produced no result");

endmodule

### hw/rtl/pwfd_step.sv
// ----------------------------------------------------------------------------
// pwfd_step
// Per-byte decode: next parser state and the result word for one byte.
// ----------------------------------------------------------------------------
module pwfd_step #(
  parameter int unsigned MAX_MESSAGE_BYTES = 65535
) (
  input  pwfd_pkg::state_t  st_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output pwfd_pkg::state_t  st_d_o,
  output logic              res_valid_o,
  output pwfd_pkg::result_t res_o
);

  localparam logic [15:0] MaxBytes = 16'(MAX_MESSAGE_BYTES);

  logic        ovf;
  logic [15:0] pos_inc;
  logic [3:0]  vc;
  logic [5:0]  vsh;
  logic [63:0] acc_or;
  logic        vdone;
  logic [3:0]  vcnt_next;
  logic [15:0] avail;
  logic        too_long;
  logic [2:0]  fk;
  logic [2:0]  rem_f;
  logic [5:0]  fsh;
  logic [63:0] acc_f32;
  logic [15:0] rem_s;

  pwfd_pkg::state_t mid;
  logic        byte_emit;
  logic [63:0] emit_value;
  logic [15:0] emit_off;
  logic [15:0] emit_len;

  // end-of-message handling
  logic        fin_start;
  logic [31:0] fin_fnum;
  logic [2:0]  fin_kind;
  logic [63:0] fin_acc;
  pwfd_pkg::phase_e fin_phase;
  logic        fin_emit;
  logic        fin_fail;
  logic [15:0] fin_off;

  assign ovf       = (st_i.pos >= MaxBytes);
  assign pos_inc   = ovf ? st_i.pos : st_i.pos + 16'd1;
  assign vc        = (st_i.vcnt > pwfd_pkg::VARINT_LAST_IDX) ? pwfd_pkg::VARINT_LAST_IDX
                                                             : st_i.vcnt;
  assign vsh       = 6'({vc, 3'b000} - {3'b000, vc});
  assign acc_or    = st_i.acc | ({57'd0, data_byte_i[6:0]} << vsh);
  assign vdone     = !data_byte_i[7] || (vc == pwfd_pkg::VARINT_LAST_IDX);
  assign vcnt_next = vdone ? 4'd0 : vc + 4'd1;
  assign avail     = MaxBytes - pos_inc;
  assign too_long  = (acc_or > {48'd0, avail});
  assign fk        = (st_i.rem > 16'd4 || st_i.rem == 16'd0) ? 3'd4 : st_i.rem[2:0];
  assign rem_f     = fk - 3'd1;
  assign fsh       = {3'd4 - fk, 3'b000};
  assign acc_f32   = st_i.acc | ({56'd0, data_byte_i} << fsh);
  assign rem_s     = (st_i.rem != 16'd0) ? st_i.rem - 16'd1 : 16'd0;

  // Next state: byte step, then return to reset after the last byte.
  always_comb begin
    mid        = st_i;
    mid.pos    = pos_inc;
    byte_emit  = 1'b0;
    emit_value = 64'd0;
    emit_off   = 16'd0;
    emit_len   = 16'd0;
    if (ovf) begin
      mid.err   = 1'b1;
      mid.phase = pwfd_pkg::PH_DRAIN;
    end else begin
      unique case (st_i.phase)
        pwfd_pkg::PH_TAG: begin
          mid.acc  = acc_or;
          mid.vcnt = vcnt_next;
          if (vdone) begin
            mid.fnum = acc_or[34:3];
            mid.kind = acc_or[2:0];
            mid.acc  = 64'd0;
            case (acc_or[2:0])
              pwfd_pkg::WK_VARINT:  mid.phase = pwfd_pkg::PH_VALUE;
              pwfd_pkg::WK_FIXED64: begin
                mid.phase = pwfd_pkg::PH_SKIP;
                mid.rem   = pwfd_pkg::FIXED64_BYTES;
              end
              pwfd_pkg::WK_LEN:     mid.phase = pwfd_pkg::PH_LENGTH;
              pwfd_pkg::WK_FIXED32: begin
                mid.phase = pwfd_pkg::PH_FIX32;
                mid.rem   = pwfd_pkg::FIXED32_BYTES;
              end
              default: begin
                mid.err   = 1'b1;
                mid.phase = pwfd_pkg::PH_DRAIN;
              end
            endcase
          end
        end
        pwfd_pkg::PH_VALUE: begin
          mid.acc  = acc_or;
          mid.vcnt = vcnt_next;
          if (vdone) begin
            byte_emit  = 1'b1;
            emit_value = acc_or;
          end
        end
        pwfd_pkg::PH_LENGTH: begin
          mid.acc  = acc_or;
          mid.vcnt = vcnt_next;
          if (vdone) begin
            if (too_long) begin
              mid.err   = 1'b1;
              mid.phase = pwfd_pkg::PH_DRAIN;
            end else if (acc_or == 64'd0) begin
              byte_emit = 1'b1;
              emit_off  = pos_inc;
            end else begin
              mid.span  = pos_inc;
              mid.rem   = acc_or[15:0];
              mid.acc   = 64'd0;
              mid.phase = pwfd_pkg::PH_SKIP;
            end
          end
        end
        pwfd_pkg::PH_SKIP: begin
          mid.rem = rem_s;
          if (rem_s == 16'd0) begin
            byte_emit = 1'b1;
            if (st_i.kind == pwfd_pkg::WK_LEN) begin
              emit_off = st_i.span;
              emit_len = pos_inc - st_i.span;
            end
          end
        end
        pwfd_pkg::PH_FIX32: begin
          mid.acc = acc_f32;
          mid.rem = {13'd0, rem_f};
          if (rem_f == 3'd0) begin
            byte_emit  = 1'b1;
            emit_value = {32'd0, acc_f32[31:0]};
          end
        end
        default: ;
      endcase
    end
    // a completed field returns the parser to the tag phase
    if (byte_emit) begin
      mid.phase = pwfd_pkg::PH_TAG;
      mid.acc   = 64'd0;
      mid.vcnt  = 4'd0;
    end
    st_d_o = last_byte_i ? pwfd_pkg::STATE_RESET : mid;
  end

  // Outputs: field from this byte, or from closing out the message.
  always_comb begin
    fin_start = (mid.phase == pwfd_pkg::PH_TAG) && (mid.vcnt != 4'd0);
    fin_fnum  = fin_start ? mid.acc[34:3] : mid.fnum;
    fin_kind  = fin_start ? mid.acc[2:0]  : mid.kind;
    fin_acc   = fin_start ? 64'd0         : mid.acc;
    fin_phase = mid.phase;
    fin_emit  = 1'b0;
    fin_fail  = 1'b0;
    fin_off   = 16'd0;
    if (fin_start) begin
      case (mid.acc[2:0])
        pwfd_pkg::WK_VARINT:  fin_phase = pwfd_pkg::PH_VALUE;
        pwfd_pkg::WK_FIXED64: fin_phase = pwfd_pkg::PH_SKIP;
        pwfd_pkg::WK_LEN:     fin_phase = pwfd_pkg::PH_LENGTH;
        pwfd_pkg::WK_FIXED32: fin_phase = pwfd_pkg::PH_FIX32;
        default: begin
          fin_phase = pwfd_pkg::PH_DRAIN;
          fin_fail  = 1'b1;
        end
      endcase
    end
    unique case (fin_phase)
      pwfd_pkg::PH_VALUE:  fin_emit = 1'b1;
      pwfd_pkg::PH_LENGTH: begin
        if (fin_acc == 64'd0) begin
          fin_emit = 1'b1;
          fin_off  = mid.pos;
        end else begin
          fin_fail = 1'b1;
        end
      end
      pwfd_pkg::PH_SKIP,
      pwfd_pkg::PH_FIX32:  fin_fail = 1'b1;
      default: ;
    endcase

    res_o = '0;
    if (byte_emit) begin
      res_o.field_valid    = 1'b1;
      res_o.field_number   = mid.fnum;
      res_o.wire_kind      = mid.kind;
      res_o.field_value    = emit_value;
      res_o.payload_offset = emit_off;
      res_o.payload_length = emit_len;
    end else if (last_byte_i && fin_emit) begin
      res_o.field_valid    = 1'b1;
      res_o.field_number   = fin_fnum;
      res_o.wire_kind      = fin_kind;
      res_o.field_value    = (fin_phase == pwfd_pkg::PH_VALUE) ? fin_acc : 64'd0;
      res_o.payload_offset = fin_off;
    end
    if (last_byte_i) begin
      res_o.end_of_message = 1'b1;
      res_o.parse_ok       = !(mid.err || (!byte_emit && fin_fail));
    end
    res_valid_o = byte_emit || last_byte_i;
  end

endmodule

### hw/rtl/pwfd_obuf.sv
// ----------------------------------------------------------------------------
// pwfd_obuf
// Result register with a skid stage behind it.
// ----------------------------------------------------------------------------
module pwfd_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pwfd_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pwfd_pkg::result_t data_o
);

  logic              out_v_q, out_v_d;
  logic              skd_v_q, skd_v_d;
  pwfd_pkg::result_t out_q, out_d;
  pwfd_pkg::result_t skd_q, skd_d;
  logic              pop;

  assign pop = out_v_q && !out_stall_i;

  always_comb begin
    out_v_d = out_v_q;
    skd_v_d = skd_v_q;
    out_d   = out_q;
    skd_d   = skd_q;
    if (pop) begin
      if (skd_v_q) begin
        out_d   = skd_q;
        skd_v_d = 1'b0;
      end else if (push_i) begin
        out_d = data_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_d   = data_i;
        out_v_d = 1'b1;
      end else begin
        // hold the new word until the output drains
        skd_d   = data_i;
        skd_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skd_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      skd_v_q <= skd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign full_o      = skd_v_q;
  assign out_valid_o = out_v_q;
  assign data_o      = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skd_v_q |-> out_v_q)
    else $error("skid holds a word while output is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skd_v_q)
    else $error("word pushed while skid is full");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skd_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid filled without a stalled output");

endmodule
